### design/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg: shared types and constants of the command packet framer
// Packet framing codes, field widths, byte positions and the queue status.
// ----------------------------------------------------------------------------
package cpf_pkg;

   localparam int BYTE_W     = 8;
   localparam int CODE_W     = 8;
   localparam int COUNT_W    = 3;
   localparam int ADDR_W     = 32;
   localparam int CHK_W      = 16;
   localparam int POS_W      = 5;
   localparam int ARG_FIELDS = 5;

   localparam logic [BYTE_W-1:0] START_HI    = 8'hEF;
   localparam logic [BYTE_W-1:0] START_LO    = 8'h01;
   localparam logic [BYTE_W-1:0] PACKET_ID   = 8'h01;
   localparam logic [BYTE_W-1:0] LENGTH_HI   = 8'h00;
   localparam logic [BYTE_W-1:0] LENGTH_BIAS = 8'h03;
   localparam logic [ADDR_W-1:0] ADDR_RESET  = 32'hFFFF_FFFF;

   localparam logic [POS_W-1:0] POS_START_HI = 5'd0;
   localparam logic [POS_W-1:0] POS_START_LO = 5'd1;
   localparam logic [POS_W-1:0] POS_ADDR_3   = 5'd2;
   localparam logic [POS_W-1:0] POS_ADDR_2   = 5'd3;
   localparam logic [POS_W-1:0] POS_ADDR_1   = 5'd4;
   localparam logic [POS_W-1:0] POS_ADDR_0   = 5'd5;
   localparam logic [POS_W-1:0] POS_PID      = 5'd6;
   localparam logic [POS_W-1:0] POS_LEN_HI   = 5'd7;
   localparam logic [POS_W-1:0] POS_LEN_LO   = 5'd8;
   localparam logic [POS_W-1:0] POS_CODE     = 5'd9;
   localparam logic [POS_W-1:0] POS_ARG0     = 5'd10;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### design/cpf_front.sv
// ----------------------------------------------------------------------------
// cpf_front: command intake
// Takes a command, saturates its argument count and lays out the queue entry.
// ----------------------------------------------------------------------------
module cpf_front #(
   parameter int MAX_ARGS = 5
) (
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic [cpf_pkg::CODE_W-1:0]                 req_command_code,
   input  logic [cpf_pkg::COUNT_W-1:0]                req_arg_count,
   input  logic [cpf_pkg::BYTE_W-1:0]                 req_arg_byte_0,
   input  logic [cpf_pkg::BYTE_W-1:0]                 req_arg_byte_1,
   input  logic [cpf_pkg::BYTE_W-1:0]                 req_arg_byte_2,
   input  logic [cpf_pkg::BYTE_W-1:0]                 req_arg_byte_3,
   input  logic [cpf_pkg::BYTE_W-1:0]                 req_arg_byte_4,
   input  cpf_pkg::queue_status_type                  q_status,
   output logic                                       q_push,
   output logic [cpf_pkg::CODE_W+cpf_pkg::COUNT_W+cpf_pkg::BYTE_W*MAX_ARGS-1:0] q_entry
);

   localparam int ARGS_LSB = cpf_pkg::CODE_W + cpf_pkg::COUNT_W;

   logic [cpf_pkg::BYTE_W-1:0]  fields[cpf_pkg::ARG_FIELDS];
   logic [cpf_pkg::COUNT_W-1:0] count_sat;

   assign fields[0] = req_arg_byte_0;
   assign fields[1] = req_arg_byte_1;
   assign fields[2] = req_arg_byte_2;
   assign fields[3] = req_arg_byte_3;
   assign fields[4] = req_arg_byte_4;

   assign count_sat = (32'(req_arg_count) > MAX_ARGS) ? cpf_pkg::COUNT_W'(MAX_ARGS)
                                                      : req_arg_count;

   assign q_entry[cpf_pkg::CODE_W-1:0]         = req_command_code;
   assign q_entry[ARGS_LSB-1:cpf_pkg::CODE_W]  = count_sat;

   for (genvar i = 0; i < MAX_ARGS; i++) begin : g_arg
      if (i < cpf_pkg::ARG_FIELDS) begin : g_field
         assign q_entry[ARGS_LSB + cpf_pkg::BYTE_W*i +: cpf_pkg::BYTE_W] = fields[i];
      end else begin : g_zero
         assign q_entry[ARGS_LSB + cpf_pkg::BYTE_W*i +: cpf_pkg::BYTE_W] = '0;
      end
   end

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

endmodule

### design/cpf_queue.sv
// ----------------------------------------------------------------------------
// cpf_queue: command queue
// Small register FIFO between intake and the byte sequencer.
// ----------------------------------------------------------------------------
module cpf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [WIDTH-1:0]          din,
   input  logic                      pop,
   output logic [WIDTH-1:0]          dout,
   output cpf_pkg::queue_status_type status
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff[DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign status.full  = (fill_ff == FILL_W'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign dout         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### design/cpf_back.sv
// ----------------------------------------------------------------------------
// cpf_back: packet byte sequencer
// Walks the head command byte by byte, accumulates the checksum and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module cpf_back #(
   parameter int MAX_ARGS = 5
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [cpf_pkg::ADDR_W-1:0]                 addr_word,
   input  cpf_pkg::queue_status_type                  q_status,
   input  logic [cpf_pkg::CODE_W+cpf_pkg::COUNT_W+cpf_pkg::BYTE_W*MAX_ARGS-1:0] q_entry,
   output logic                                       q_pop,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [cpf_pkg::BYTE_W-1:0]                 rsp_out_byte,
   output logic                                       rsp_end_of_packet
);

   localparam int ARGS_LSB = cpf_pkg::CODE_W + cpf_pkg::COUNT_W;

   logic [cpf_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [cpf_pkg::CHK_W-1:0]   chk_ff, chk_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cpf_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [cpf_pkg::CODE_W-1:0]  code;
   logic [cpf_pkg::COUNT_W-1:0] count;
   logic [cpf_pkg::POS_W-1:0]   chk_pos;
   logic [cpf_pkg::BYTE_W-1:0]  arg_sel;
   logic [cpf_pkg::BYTE_W-1:0]  byte_sel;
   logic                        is_last, in_sum, advance, issue;

   assign code    = q_entry[cpf_pkg::CODE_W-1:0];
   assign count   = q_entry[ARGS_LSB-1:cpf_pkg::CODE_W];
   assign chk_pos = cpf_pkg::POS_ARG0 + cpf_pkg::POS_W'(count);
   assign is_last = (pos_ff == chk_pos + 1'b1);
   assign in_sum  = (pos_ff >= cpf_pkg::POS_PID) && (pos_ff < chk_pos);
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign issue   = advance && !q_status.empty;
   assign q_pop   = issue && is_last;

   always_comb begin
      arg_sel = '0;
      for (int i = 0; i < MAX_ARGS; i++) begin
         if (pos_ff == cpf_pkg::POS_ARG0 + cpf_pkg::POS_W'(i)) begin
            arg_sel = q_entry[ARGS_LSB + cpf_pkg::BYTE_W*i +: cpf_pkg::BYTE_W];
         end
      end
   end

   always_comb begin
      priority if (pos_ff == cpf_pkg::POS_START_HI) begin
         byte_sel = cpf_pkg::START_HI;
      end else if (pos_ff == cpf_pkg::POS_START_LO) begin
         byte_sel = cpf_pkg::START_LO;
      end else if (pos_ff == cpf_pkg::POS_ADDR_3) begin
         byte_sel = addr_word[31:24];
      end else if (pos_ff == cpf_pkg::POS_ADDR_2) begin
         byte_sel = addr_word[23:16];
      end else if (pos_ff == cpf_pkg::POS_ADDR_1) begin
         byte_sel = addr_word[15:8];
      end else if (pos_ff == cpf_pkg::POS_ADDR_0) begin
         byte_sel = addr_word[7:0];
      end else if (pos_ff == cpf_pkg::POS_PID) begin
         byte_sel = cpf_pkg::PACKET_ID;
      end else if (pos_ff == cpf_pkg::POS_LEN_HI) begin
         byte_sel = cpf_pkg::LENGTH_HI;
      end else if (pos_ff == cpf_pkg::POS_LEN_LO) begin
         byte_sel = cpf_pkg::BYTE_W'(count) + cpf_pkg::LENGTH_BIAS;
      end else if (pos_ff == cpf_pkg::POS_CODE) begin
         byte_sel = code;
      end else if (pos_ff < chk_pos) begin
         byte_sel = arg_sel;
      end else if (pos_ff == chk_pos) begin
         byte_sel = chk_ff[15:8];
      end else begin
         byte_sel = chk_ff[7:0];
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      chk_in       = chk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = issue;
      end
      if (issue) begin
         rsp_byte_in = byte_sel;
         rsp_last_in = is_last;
         if (is_last) begin
            pos_in = '0;
            chk_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (in_sum) begin
               chk_in = chk_ff + cpf_pkg::CHK_W'(byte_sel);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         chk_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_end_of_packet = rsp_last_ff;

endmodule

### design/command_packet_framer_core.sv
// The first packet byte passes through the command queue and then the
// registered result channel. A packet is 12 + argument count bytes (12 to
// 12 + MAX_ARGS), one byte per cycle from the byte sequencer unless stalled;
// commands queue two deep, so the next follows its predecessor with no gap.
// Reset: synchronous; empties the queue, idles the sequencer, drops rsp_valid
// and sets the device address to FFFFFFFF.
// ----------------------------------------------------------------------------
// command_packet_framer_core: command packet framer
// Frames commands into serial packets with header, device address, length,
// arguments and a 16-bit additive checksum.
// ----------------------------------------------------------------------------
module command_packet_framer_core #(
   parameter int MAX_ARGS = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [cpf_pkg::ADDR_W-1:0]        csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cpf_pkg::CODE_W-1:0]        req_command_code,
   input  logic [cpf_pkg::COUNT_W-1:0]       req_arg_count,
   input  logic [cpf_pkg::BYTE_W-1:0]        req_arg_byte_0,
   input  logic [cpf_pkg::BYTE_W-1:0]        req_arg_byte_1,
   input  logic [cpf_pkg::BYTE_W-1:0]        req_arg_byte_2,
   input  logic [cpf_pkg::BYTE_W-1:0]        req_arg_byte_3,
   input  logic [cpf_pkg::BYTE_W-1:0]        req_arg_byte_4,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cpf_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_end_of_packet
);

   localparam int ENTRY_W     = cpf_pkg::CODE_W + cpf_pkg::COUNT_W + cpf_pkg::BYTE_W*MAX_ARGS;
   localparam int QUEUE_DEPTH = 2;

   logic [cpf_pkg::ADDR_W-1:0] dev_addr_ff, dev_addr_in;
   cpf_pkg::queue_status_type  q_status;
   logic                       q_push, q_pop;
   logic [ENTRY_W-1:0]         q_din, q_dout;

   assign dev_addr_in = csr_write_enable ? csr_write_data : dev_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= cpf_pkg::ADDR_RESET;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   cpf_front #(
      .MAX_ARGS (MAX_ARGS)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command_code (req_command_code),
      .req_arg_count    (req_arg_count),
      .req_arg_byte_0   (req_arg_byte_0),
      .req_arg_byte_1   (req_arg_byte_1),
      .req_arg_byte_2   (req_arg_byte_2),
      .req_arg_byte_3   (req_arg_byte_3),
      .req_arg_byte_4   (req_arg_byte_4),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_entry          (q_din)
   );

   cpf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .din    (q_din),
      .pop    (q_pop),
      .dout   (q_dout),
      .status (q_status)
   );

   cpf_back #(
      .MAX_ARGS (MAX_ARGS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .addr_word         (dev_addr_ff),
      .q_status          (q_status),
      .q_entry           (q_dout),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_packet (rsp_end_of_packet)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("queue push while full");

   a_pop_loads_last_byte: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_valid && rsp_end_of_packet))
      else $error("command retired without its final byte");

   a_idle_when_empty: assert property (@(posedge clock) disable iff (reset)
      (q_status.empty && (!rsp_valid || !rsp_stall)) |=> !rsp_valid)
      else $error("byte issued with no queued command");
`endif

endmodule
